// ===== hdl/imudr_pkg.sv =====
package imudr_pkg;

    // Field widths of the channels and the configuration register.
    localparam int DT_W     = 16;
    localparam int ACCEL_W  = 16;
    localparam int YAW_W    = 16;
    localparam int POS_W    = 32;
    localparam int HEAD_W   = 32;
    localparam int ANGLE_W  = 16;

    localparam logic [DT_W-1:0] TIME_STEP_RESET = 16'd66;

    // Shared multiplier: the widest operand is the 42-bit a*dt product fed back.
    localparam int MUL_A_W = 44;
    localparam int MUL_B_W = 19;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // 8/pi in turns per radian, scaled by 2^16.
    localparam logic signed [MUL_B_W-1:0] RAD_TO_TURN = 19'sd166886;

    // CORDIC working precision.
    localparam int CORD_W      = 34;
    localparam int CORD_FRAC   = 30;
    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam int ANGLE_TABLE_LEN = 24;
    localparam int ANGLE_IDX_W     = 5;
    localparam int ANGLE_STEP_W    = 30;

    // World acceleration, kinematic increments and the saturating sum.
    localparam int AE_W  = 26;
    localparam int INC_W = 34;
    localparam int SUM_W = 36;

    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_HEAD_MUL,
        ST_HEAD_SCALE,
        ST_HEAD_ADD,
        ST_CORD_LOAD,
        ST_CORD_RUN,
        ST_TRIG,
        ST_ROT0,
        ST_ROT1,
        ST_ROT2,
        ST_ROT3,
        ST_ROT4,
        ST_ROT5,
        ST_KIN0,
        ST_KIN1,
        ST_KIN2,
        ST_KIN3,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_YAW_DT,
        MUL_P_K,
        MUL_C_F,
        MUL_SN_S,
        MUL_SN_F,
        MUL_C_S,
        MUL_VEL_DT,
        MUL_ACC_DT,
        MUL_PROD_DT
    } mul_sel_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_HEAD_UPD,
        DP_CORD_LOAD,
        DP_CORD_STEP,
        DP_TRIG,
        DP_ACC_LOAD,
        DP_ACC_SUB,
        DP_AE_RELOAD,
        DP_ACC_ADD,
        DP_AN_LATCH,
        DP_VT,
        DP_DV,
        DP_KIN_UPD,
        DP_OUT_LOAD
    } dp_op_t;

    typedef struct packed {
        logic     take;
        mul_sel_t mul_sel;
        dp_op_t   op;
        logic     axis;
    } dp_cmd_t;

    typedef struct packed {
        logic cordic_last;
    } dp_status_t;

    // Arctangent of 2^-i in units of 2^32 per turn.
    function automatic logic [ANGLE_STEP_W-1:0] angle_step(input logic [ANGLE_IDX_W-1:0] idx);
        logic [ANGLE_STEP_W-1:0] v;
        unique case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41721;
            5'd15:   v = 30'd20860;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2607;
            5'd19:   v = 30'd1303;
            5'd20:   v = 30'd651;
            5'd21:   v = 30'd325;
            5'd22:   v = 30'd162;
            5'd23:   v = 30'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [POS_W-1:0] r;
        priority if (v > SUM_W'(POS_MAX))
            r = POS_MAX;
        else if (v < SUM_W'(POS_MIN))
            r = POS_MIN;
        else
            r = POS_W'(v);
        return r;
    endfunction

endpackage

// ===== hdl/imudr_if.sv =====
interface imudr_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [imudr_pkg::ACCEL_W-1:0] accel_fwd;
    logic signed [imudr_pkg::ACCEL_W-1:0] accel_side;
    logic signed [imudr_pkg::YAW_W-1:0]   yaw_rate;

    modport source (output valid, output accel_fwd, output accel_side, output yaw_rate,
                    input ready);
    modport sink   (input valid, input accel_fwd, input accel_side, input yaw_rate,
                    output ready);
endinterface

interface imudr_pose_if;
    logic                               valid;
    logic                               ready;
    logic signed [imudr_pkg::POS_W-1:0] east_pos;
    logic signed [imudr_pkg::POS_W-1:0] north_pos;
    logic [imudr_pkg::ANGLE_W-1:0]      heading_angle;

    modport source (output valid, output east_pos, output north_pos, output heading_angle,
                    input ready);
    modport sink   (input valid, input east_pos, input north_pos, input heading_angle,
                    output ready);
endinterface

// ===== hdl/imudr_ctrl.sv =====
module imudr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  imudr_pkg::dp_status_t status,
    output imudr_pkg::dp_cmd_t    cmd
);

    imudr_pkg::ctrl_state_t state_reg;
    imudr_pkg::ctrl_state_t state_next;
    logic                   axis_reg;
    logic                   axis_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= imudr_pkg::ST_IDLE;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            imudr_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = imudr_pkg::ST_HEAD_MUL;
            end
            imudr_pkg::ST_HEAD_MUL:   state_next = imudr_pkg::ST_HEAD_SCALE;
            imudr_pkg::ST_HEAD_SCALE: state_next = imudr_pkg::ST_HEAD_ADD;
            imudr_pkg::ST_HEAD_ADD:   state_next = imudr_pkg::ST_CORD_LOAD;
            imudr_pkg::ST_CORD_LOAD:  state_next = imudr_pkg::ST_CORD_RUN;
            imudr_pkg::ST_CORD_RUN:
            begin
                if (status.cordic_last)
                    state_next = imudr_pkg::ST_TRIG;
            end
            imudr_pkg::ST_TRIG:       state_next = imudr_pkg::ST_ROT0;
            imudr_pkg::ST_ROT0:       state_next = imudr_pkg::ST_ROT1;
            imudr_pkg::ST_ROT1:       state_next = imudr_pkg::ST_ROT2;
            imudr_pkg::ST_ROT2:       state_next = imudr_pkg::ST_ROT3;
            imudr_pkg::ST_ROT3:       state_next = imudr_pkg::ST_ROT4;
            imudr_pkg::ST_ROT4:       state_next = imudr_pkg::ST_ROT5;
            imudr_pkg::ST_ROT5:
            begin
                state_next = imudr_pkg::ST_KIN0;
                axis_next  = 1'b0;
            end
            imudr_pkg::ST_KIN0:       state_next = imudr_pkg::ST_KIN1;
            imudr_pkg::ST_KIN1:       state_next = imudr_pkg::ST_KIN2;
            imudr_pkg::ST_KIN2:       state_next = imudr_pkg::ST_KIN3;
            imudr_pkg::ST_KIN3:
            begin
                // East first, then the same four steps for north.
                if (!axis_reg)
                begin
                    state_next = imudr_pkg::ST_KIN0;
                    axis_next  = 1'b1;
                end
                else
                    state_next = imudr_pkg::ST_OUT;
            end
            imudr_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next     = imudr_pkg::ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:                  state_next = imudr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.take     = 1'b0;
        cmd.mul_sel  = imudr_pkg::MUL_NONE;
        cmd.op       = imudr_pkg::DP_NONE;
        cmd.axis     = axis_reg;
        unique case (state_reg)
            imudr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            imudr_pkg::ST_HEAD_MUL:   cmd.mul_sel = imudr_pkg::MUL_YAW_DT;
            imudr_pkg::ST_HEAD_SCALE: cmd.mul_sel = imudr_pkg::MUL_P_K;
            imudr_pkg::ST_HEAD_ADD:   cmd.op      = imudr_pkg::DP_HEAD_UPD;
            imudr_pkg::ST_CORD_LOAD:  cmd.op      = imudr_pkg::DP_CORD_LOAD;
            imudr_pkg::ST_CORD_RUN:   cmd.op      = imudr_pkg::DP_CORD_STEP;
            imudr_pkg::ST_TRIG:       cmd.op      = imudr_pkg::DP_TRIG;
            imudr_pkg::ST_ROT0:       cmd.mul_sel = imudr_pkg::MUL_C_F;
            imudr_pkg::ST_ROT1:
            begin
                cmd.mul_sel = imudr_pkg::MUL_SN_S;
                cmd.op      = imudr_pkg::DP_ACC_LOAD;
            end
            imudr_pkg::ST_ROT2:
            begin
                cmd.mul_sel = imudr_pkg::MUL_SN_F;
                cmd.op      = imudr_pkg::DP_ACC_SUB;
            end
            imudr_pkg::ST_ROT3:
            begin
                cmd.mul_sel = imudr_pkg::MUL_C_S;
                cmd.op      = imudr_pkg::DP_AE_RELOAD;
            end
            imudr_pkg::ST_ROT4:       cmd.op      = imudr_pkg::DP_ACC_ADD;
            imudr_pkg::ST_ROT5:       cmd.op      = imudr_pkg::DP_AN_LATCH;
            imudr_pkg::ST_KIN0:       cmd.mul_sel = imudr_pkg::MUL_VEL_DT;
            imudr_pkg::ST_KIN1:
            begin
                cmd.mul_sel = imudr_pkg::MUL_ACC_DT;
                cmd.op      = imudr_pkg::DP_VT;
            end
            imudr_pkg::ST_KIN2:
            begin
                cmd.mul_sel = imudr_pkg::MUL_PROD_DT;
                cmd.op      = imudr_pkg::DP_DV;
            end
            imudr_pkg::ST_KIN3:       cmd.op      = imudr_pkg::DP_KIN_UPD;
            imudr_pkg::ST_OUT:
            begin
                if (out_free)
                    cmd.op = imudr_pkg::DP_OUT_LOAD;
            end
            default:                  cmd.op      = imudr_pkg::DP_NONE;
        endcase
    end

endmodule

// ===== hdl/imudr_datapath.sv =====
module imudr_datapath #(
    parameter int TRIG_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [imudr_pkg::DT_W-1:0]           cfg_wdata,
    input  logic signed [imudr_pkg::ACCEL_W-1:0] accel_fwd,
    input  logic signed [imudr_pkg::ACCEL_W-1:0] accel_side,
    input  logic signed [imudr_pkg::YAW_W-1:0]   yaw_rate,
    input  imudr_pkg::dp_cmd_t                   cmd,
    output imudr_pkg::dp_status_t                status,
    output logic signed [imudr_pkg::POS_W-1:0]   east_pos,
    output logic signed [imudr_pkg::POS_W-1:0]   north_pos,
    output logic [imudr_pkg::ANGLE_W-1:0]        heading_angle
);

    localparam int DT_W      = imudr_pkg::DT_W;
    localparam int ACCEL_W   = imudr_pkg::ACCEL_W;
    localparam int YAW_W     = imudr_pkg::YAW_W;
    localparam int POS_W     = imudr_pkg::POS_W;
    localparam int HEAD_W    = imudr_pkg::HEAD_W;
    localparam int ANGLE_W   = imudr_pkg::ANGLE_W;
    localparam int MUL_A_W   = imudr_pkg::MUL_A_W;
    localparam int MUL_B_W   = imudr_pkg::MUL_B_W;
    localparam int MUL_P_W   = imudr_pkg::MUL_P_W;
    localparam int CORD_W    = imudr_pkg::CORD_W;
    localparam int IDX_W     = imudr_pkg::ANGLE_IDX_W;
    localparam int AE_W      = imudr_pkg::AE_W;
    localparam int INC_W     = imudr_pkg::INC_W;
    localparam int SUM_W     = imudr_pkg::SUM_W;
    localparam int TRIG_W    = TRIG_BITS + 2;
    localparam int CNT_W     = $clog2(TRIG_BITS);
    localparam int TRIG_SHIFT = imudr_pkg::CORD_FRAC - TRIG_BITS;
    localparam int ROT_SHIFT  = TRIG_BITS - 8;

    localparam logic signed [CORD_W-1:0]  TRIG_HALF = CORD_W'(1) << (TRIG_SHIFT - 1);
    localparam logic signed [CORD_W-1:0]  TRIG_ONE  = CORD_W'(1) << TRIG_BITS;
    localparam logic signed [MUL_P_W-1:0] ROT_HALF  = MUL_P_W'(1) << (ROT_SHIFT - 1);
    localparam logic signed [MUL_P_W-1:0] HALF_16   = MUL_P_W'(1) << 15;
    localparam logic signed [MUL_P_W-1:0] HALF_33   = MUL_P_W'(1) << 32;
    localparam logic [CNT_W-1:0]          CNT_LAST  = CNT_W'(TRIG_BITS - 1);

    // Sample and configuration.
    logic [DT_W-1:0]            time_step_reg;
    logic signed [ACCEL_W-1:0]  fwd_reg;
    logic signed [ACCEL_W-1:0]  side_reg;
    logic signed [YAW_W-1:0]    yaw_reg;

    // Dead-reckoning state.
    logic [HEAD_W-1:0]          heading_reg;
    logic signed [POS_W-1:0]    pos_e_reg;
    logic signed [POS_W-1:0]    pos_n_reg;
    logic signed [POS_W-1:0]    vel_e_reg;
    logic signed [POS_W-1:0]    vel_n_reg;

    // Working registers.
    logic signed [MUL_P_W-1:0]  prod_reg;
    logic signed [MUL_P_W-1:0]  acc_reg;
    logic signed [CORD_W-1:0]   x_reg;
    logic signed [CORD_W-1:0]   y_reg;
    logic signed [CORD_W-1:0]   z_reg;
    logic                       flip_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic signed [TRIG_W-1:0]   c_reg;
    logic signed [TRIG_W-1:0]   sn_reg;
    logic signed [AE_W-1:0]     ae_reg;
    logic signed [AE_W-1:0]     an_reg;
    logic signed [INC_W-1:0]    vt_reg;
    logic signed [INC_W-1:0]    dv_reg;

    // Result register.
    logic signed [POS_W-1:0]    out_e_reg;
    logic signed [POS_W-1:0]    out_n_reg;
    logic [ANGLE_W-1:0]         out_head_reg;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  mul_p;
    logic signed [MUL_B_W-1:0]  dt_op;

    logic signed [MUL_P_W-1:0]  head_round;
    logic                       fold;
    logic [HEAD_W-1:0]          fold_angle;

    logic signed [CORD_W-1:0]   dx;
    logic signed [CORD_W-1:0]   dy;
    logic signed [CORD_W-1:0]   step_ext;
    logic signed [CORD_W-1:0]   x_step;
    logic signed [CORD_W-1:0]   y_step;
    logic signed [CORD_W-1:0]   z_step;

    logic signed [CORD_W-1:0]   x_sign;
    logic signed [CORD_W-1:0]   y_sign;
    logic signed [CORD_W-1:0]   x_rnd;
    logic signed [CORD_W-1:0]   y_rnd;
    logic signed [CORD_W-1:0]   x_clamp;
    logic signed [CORD_W-1:0]   y_clamp;

    logic signed [MUL_P_W-1:0]  rot_sum;
    logic signed [MUL_P_W-1:0]  rot_rnd;
    logic signed [MUL_P_W-1:0]  sh16_rnd;
    logic signed [MUL_P_W-1:0]  sh33_rnd;

    logic signed [POS_W-1:0]    pos_sel;
    logic signed [POS_W-1:0]    vel_sel;
    logic signed [AE_W-1:0]     a_sel;
    logic signed [SUM_W-1:0]    pos_sum;
    logic signed [SUM_W-1:0]    vel_sum;
    logic signed [POS_W-1:0]    pos_new;
    logic signed [POS_W-1:0]    vel_new;

    assign dt_op   = MUL_B_W'({1'b0, time_step_reg});
    assign pos_sel = cmd.axis ? pos_n_reg : pos_e_reg;
    assign vel_sel = cmd.axis ? vel_n_reg : vel_e_reg;
    assign a_sel   = cmd.axis ? an_reg : ae_reg;

    // Operand selection for the one shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            imudr_pkg::MUL_YAW_DT:
            begin
                mul_a = MUL_A_W'(yaw_reg);
                mul_b = dt_op;
            end
            imudr_pkg::MUL_P_K:
            begin
                mul_a = MUL_A_W'($signed(prod_reg[32:0]));
                mul_b = imudr_pkg::RAD_TO_TURN;
            end
            imudr_pkg::MUL_C_F:
            begin
                mul_a = MUL_A_W'(c_reg);
                mul_b = MUL_B_W'(fwd_reg);
            end
            imudr_pkg::MUL_SN_S:
            begin
                mul_a = MUL_A_W'(sn_reg);
                mul_b = MUL_B_W'(side_reg);
            end
            imudr_pkg::MUL_SN_F:
            begin
                mul_a = MUL_A_W'(sn_reg);
                mul_b = MUL_B_W'(fwd_reg);
            end
            imudr_pkg::MUL_C_S:
            begin
                mul_a = MUL_A_W'(c_reg);
                mul_b = MUL_B_W'(side_reg);
            end
            imudr_pkg::MUL_VEL_DT:
            begin
                mul_a = MUL_A_W'(vel_sel);
                mul_b = dt_op;
            end
            imudr_pkg::MUL_ACC_DT:
            begin
                mul_a = MUL_A_W'(a_sel);
                mul_b = dt_op;
            end
            imudr_pkg::MUL_PROD_DT:
            begin
                mul_a = $signed(prod_reg[MUL_A_W-1:0]);
                mul_b = dt_op;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Heading: round the scaled increment and wrap modulo one turn.
    assign head_round = prod_reg + HALF_16;
    assign fold       = heading_reg[HEAD_W-1] ^ heading_reg[HEAD_W-2];
    assign fold_angle = {heading_reg[HEAD_W-1] ^ fold, heading_reg[HEAD_W-2:0]};

    // One CORDIC rotation per cycle.
    assign dx       = y_reg >>> cnt_reg;
    assign dy       = x_reg >>> cnt_reg;
    assign step_ext = CORD_W'(imudr_pkg::angle_step(IDX_W'(cnt_reg)));

    always_comb
    begin
        if (!z_reg[CORD_W-1])
        begin
            x_step = x_reg - dx;
            y_step = y_reg + dy;
            z_step = z_reg - step_ext;
        end
        else
        begin
            x_step = x_reg + dx;
            y_step = y_reg - dy;
            z_step = z_reg + step_ext;
        end
    end

    // Undo the half-turn fold, round to the trig precision and clamp to unity.
    assign x_sign = flip_reg ? -x_reg : x_reg;
    assign y_sign = flip_reg ? -y_reg : y_reg;
    assign x_rnd  = (x_sign + TRIG_HALF) >>> TRIG_SHIFT;
    assign y_rnd  = (y_sign + TRIG_HALF) >>> TRIG_SHIFT;

    always_comb
    begin
        priority if (x_rnd > TRIG_ONE)
            x_clamp = TRIG_ONE;
        else if (x_rnd < -TRIG_ONE)
            x_clamp = -TRIG_ONE;
        else
            x_clamp = x_rnd;
        priority if (y_rnd > TRIG_ONE)
            y_clamp = TRIG_ONE;
        else if (y_rnd < -TRIG_ONE)
            y_clamp = -TRIG_ONE;
        else
            y_clamp = y_rnd;
    end

    assign rot_sum  = acc_reg + prod_reg;
    assign rot_rnd  = (acc_reg + ROT_HALF) >>> ROT_SHIFT;
    assign sh16_rnd = (prod_reg + HALF_16) >>> 16;
    assign sh33_rnd = (prod_reg + HALF_33) >>> 33;

    assign pos_sum = SUM_W'(pos_sel) + SUM_W'(vt_reg)
                     + SUM_W'($signed(sh33_rnd[AE_W-1:0]));
    assign vel_sum = SUM_W'(vel_sel) + SUM_W'(dv_reg);
    assign pos_new = imudr_pkg::sat_pos(pos_sum);
    assign vel_new = imudr_pkg::sat_pos(vel_sum);

    assign status.cordic_last = (cnt_reg == CNT_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= imudr_pkg::TIME_STEP_RESET;
            heading_reg   <= '0;
            pos_e_reg     <= '0;
            pos_n_reg     <= '0;
            vel_e_reg     <= '0;
            vel_n_reg     <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
                time_step_reg <= cfg_wdata;
            if (cmd.op == imudr_pkg::DP_HEAD_UPD)
                heading_reg <= heading_reg + head_round[HEAD_W+15:16];
            if (cmd.op == imudr_pkg::DP_CORD_LOAD)
                cnt_reg <= '0;
            else if (cmd.op == imudr_pkg::DP_CORD_STEP)
                cnt_reg <= cnt_reg + CNT_W'(1);
            if (cmd.op == imudr_pkg::DP_KIN_UPD)
            begin
                if (cmd.axis)
                begin
                    pos_n_reg <= pos_new;
                    vel_n_reg <= vel_new;
                end
                else
                begin
                    pos_e_reg <= pos_new;
                    vel_e_reg <= vel_new;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            fwd_reg  <= accel_fwd;
            side_reg <= accel_side;
            yaw_reg  <= yaw_rate;
        end
        if (cmd.mul_sel != imudr_pkg::MUL_NONE)
            prod_reg <= mul_p;
        unique case (cmd.op)
            imudr_pkg::DP_CORD_LOAD:
            begin
                x_reg    <= imudr_pkg::CORDIC_GAIN;
                y_reg    <= '0;
                z_reg    <= CORD_W'($signed(fold_angle));
                flip_reg <= fold;
            end
            imudr_pkg::DP_CORD_STEP:
            begin
                x_reg <= x_step;
                y_reg <= y_step;
                z_reg <= z_step;
            end
            imudr_pkg::DP_TRIG:
            begin
                c_reg  <= x_clamp[TRIG_W-1:0];
                sn_reg <= y_clamp[TRIG_W-1:0];
            end
            imudr_pkg::DP_ACC_LOAD:  acc_reg <= prod_reg;
            imudr_pkg::DP_ACC_SUB:   acc_reg <= acc_reg - prod_reg;
            imudr_pkg::DP_AE_RELOAD:
            begin
                ae_reg  <= rot_rnd[AE_W-1:0];
                acc_reg <= prod_reg;
            end
            imudr_pkg::DP_ACC_ADD:   acc_reg <= rot_sum;
            imudr_pkg::DP_AN_LATCH:  an_reg  <= rot_rnd[AE_W-1:0];
            imudr_pkg::DP_VT:        vt_reg  <= sh16_rnd[INC_W-1:0];
            imudr_pkg::DP_DV:        dv_reg  <= sh16_rnd[INC_W-1:0];
            imudr_pkg::DP_OUT_LOAD:
            begin
                out_e_reg    <= pos_e_reg;
                out_n_reg    <= pos_n_reg;
                out_head_reg <= heading_reg[HEAD_W-1:HEAD_W-ANGLE_W];
            end
            default:
            begin
            end
        endcase
    end

    assign east_pos      = out_e_reg;
    assign north_pos     = out_n_reg;
    assign heading_angle = out_head_reg;

endmodule

// ===== hdl/imu_dead_reckoning_core.sv =====
// Channel   Direction  Payload                                   Handshake
// sample    in         accel_fwd, accel_side, yaw_rate           valid/ready
// pose      out        east_pos, north_pos, heading_angle        valid/ready
// cfg       in         cfg_wdata (time step)                     cfg_we, no wait
//
// One sample runs from transfer to result through the CORDIC loop of one
// rotation per cycle and the single shared multiplier that handles all
// twelve products in turn.
// A new sample is taken as soon as the previous one has been written to the
// output register, so samples are processed one at a time; the
// result then waits there for its transfer, and the next result waits for it.
// rst_n clears state, heading, position and velocity at once and loads the
// default time step.
module imu_dead_reckoning_core #(
    parameter int TRIG_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [imudr_pkg::DT_W-1:0]   cfg_wdata,
    imudr_sample_if.sink                 sample,
    imudr_pose_if.source                 pose
);

    imudr_pkg::dp_cmd_t    cmd;
    imudr_pkg::dp_status_t status;
    logic                  in_ready;
    logic                  out_valid;

    imudr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (pose.ready),
        .status    (status),
        .cmd       (cmd)
    );

    imudr_datapath #(
        .TRIG_BITS (TRIG_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .accel_fwd     (sample.accel_fwd),
        .accel_side    (sample.accel_side),
        .yaw_rate      (sample.yaw_rate),
        .cmd           (cmd),
        .status        (status),
        .east_pos      (pose.east_pos),
        .north_pos     (pose.north_pos),
        .heading_angle (pose.heading_angle)
    );

    assign sample.ready = in_ready;
    assign pose.valid   = out_valid;

endmodule

// ===== hdl/imudr_checker.sv =====
module imudr_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [imudr_pkg::POS_W-1:0] east_pos,
    input logic signed [imudr_pkg::POS_W-1:0] north_pos,
    input logic [imudr_pkg::ANGLE_W-1:0]      heading_angle
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("pose valid dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(east_pos) && $stable(north_pos)
                                    && $stable(heading_angle))
        else $error("pose payload changed while stalled");

    // One sample at a time: a transfer closes the input until its result is out.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second sample taken while one is in progress");

    // A result only appears at the end of processing, when the input was closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result raised without a sample in progress");

endmodule

bind imu_dead_reckoning_core imudr_checker u_imudr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sample.valid),
    .in_ready      (sample.ready),
    .out_valid     (pose.valid),
    .out_ready     (pose.ready),
    .east_pos      (pose.east_pos),
    .north_pos     (pose.north_pos),
    .heading_angle (pose.heading_angle)
);
